>>> src/uted_pkg.sv
package uted_pkg;

    localparam int ENTITY_NAME_MAX_DEF = 6;
    localparam int CP_W = 21;
    localparam int OUT_MAX = 8;
    localparam int NAME_LEN_W = 4;
    localparam int ENT_COUNT = 6;

    localparam logic [7:0] CHAR_AMP = 8'h26;
    localparam logic [7:0] CHAR_SEMI = 8'h3B;
    localparam logic [CP_W-1:0] CP_SPACE = 21'h20;
    localparam logic [CP_W-1:0] CP_AMP = 21'h26;

    typedef enum logic [1:0] {
        CASE_NONE,
        CASE_UPPER,
        CASE_LOWER,
        CASE_CAP
    } case_mode_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_string;
    } in_t;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            string_end;
        logic            run_last;
    } out_t;

    typedef enum logic [1:0] {
        OSEL_NONE,
        OSEL_HELD,
        OSEL_RES
    } out_sel_t;

    typedef struct packed {
        logic     step;
        logic     from_queue;
        out_sel_t out_sel;
        logic     out_run_last;
        logic     held_load;
    } cmd_t;

    typedef struct packed {
        logic emit;
        logic replay;
        logic q_one;
        logic out_free;
    } status_t;

    typedef logic [0:3][7:0] name4_t;

    typedef struct packed {
        logic            hit;
        logic [CP_W-1:0] cp;
    } ent_match_t;

    localparam name4_t ENT_NAME [ENT_COUNT] = '{
        {"n", "b", "s", "p"},
        {"l", "t", 8'h00, 8'h00},
        {"g", "t", 8'h00, 8'h00},
        {"a", "m", "p", 8'h00},
        {"q", "u", "o", "t"},
        {"a", "p", "o", "s"}
    };
    localparam logic [NAME_LEN_W-1:0] ENT_LEN [ENT_COUNT] = '{
        4'd4, 4'd2, 4'd2, 4'd3, 4'd4, 4'd4
    };
    localparam logic [CP_W-1:0] ENT_CP [ENT_COUNT] = '{
        21'd160, 21'd60, 21'd62, 21'd38, 21'd34, 21'd39
    };

    function automatic ent_match_t ent_match(name4_t name, logic [NAME_LEN_W-1:0] len);
        ent_match_t r;
        logic eq;
        r = '0;
        for (int k = ENT_COUNT - 1; k >= 0; k--) begin
            eq = (len == ENT_LEN[k]);
            for (int j = 0; j < 4; j++) begin
                if (NAME_LEN_W'(j) < len && name[j] != ENT_NAME[k][j]) begin
                    eq = 1'b0;
                end
            end
            if (eq) begin
                r.hit = 1'b1;
                r.cp = ENT_CP[k];
            end
        end
        return r;
    endfunction

endpackage

>>> src/uted_ctrl.sv
module uted_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  uted_pkg::status_t status,
    output uted_pkg::cmd_t    cmd
);
    import uted_pkg::*;

    localparam int CNT_W = $clog2(OUT_MAX + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REPLAY,
        ST_FLUSH
    } state_t;

    state_t           state_reg, state_next;
    logic             held_v_reg, held_v_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_comb begin
        logic kept;
        logic step_end;
        logic wr_out;
        kept = 1'b0;
        step_end = 1'b0;
        wr_out = 1'b0;
        cmd = '0;
        cmd.out_sel = OSEL_NONE;
        s_ready = 1'b0;
        state_next = state_reg;
        held_v_next = held_v_reg;
        cnt_next = cnt_reg;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = status.out_free;
                if (s_valid && status.out_free) begin
                    cmd.step = 1'b1;
                    if (status.replay) begin
                        cmd.held_load = 1'b1;
                        held_v_next = 1'b1;
                        cnt_next = CNT_W'(1);
                        state_next = ST_REPLAY;
                    end else if (status.emit) begin
                        cmd.out_sel = OSEL_RES;
                        cmd.out_run_last = 1'b1;
                    end
                end
            end
            ST_REPLAY: begin
                cmd.from_queue = 1'b1;
                kept = status.emit && (cnt_reg < CNT_W'(OUT_MAX));
                step_end = !status.replay && status.q_one;
                wr_out = (kept && held_v_reg) || (step_end && (kept || held_v_reg));
                if (!wr_out || status.out_free) begin
                    cmd.step = 1'b1;
                    if (kept) begin
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                    if (kept && held_v_reg) begin
                        cmd.out_sel = OSEL_HELD;
                        cmd.held_load = 1'b1;
                        if (step_end) begin
                            state_next = ST_FLUSH;
                        end
                    end else if (kept) begin
                        if (step_end) begin
                            cmd.out_sel = OSEL_RES;
                            cmd.out_run_last = 1'b1;
                            state_next = ST_IDLE;
                        end else begin
                            cmd.held_load = 1'b1;
                            held_v_next = 1'b1;
                        end
                    end else if (step_end) begin
                        if (held_v_reg) begin
                            cmd.out_sel = OSEL_HELD;
                            cmd.out_run_last = 1'b1;
                            held_v_next = 1'b0;
                        end
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_FLUSH: begin
                if (status.out_free) begin
                    cmd.out_sel = OSEL_HELD;
                    cmd.out_run_last = 1'b1;
                    held_v_next = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            held_v_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            state_reg <= state_next;
            held_v_reg <= held_v_next;
            cnt_reg <= cnt_next;
        end
    end

    a_idle_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |-> !held_v_reg)
        else $error("held result left over in idle");

    a_flush_held: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_FLUSH |-> held_v_reg)
        else $error("flush without held result");

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(OUT_MAX))
        else $error("result count overrun");

endmodule

>>> src/uted_dp.sv
module uted_dp #(
    parameter int ENTITY_NAME_MAX = uted_pkg::ENTITY_NAME_MAX_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  uted_pkg::in_t     s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output uted_pkg::out_t    m_data,
    input  logic              cfg_valid,
    input  logic [1:0]        cfg_data,
    input  uted_pkg::cmd_t    cmd,
    output uted_pkg::status_t status
);
    import uted_pkg::*;

    localparam int Q = ENTITY_NAME_MAX + 1;
    localparam int IDX_W = $clog2(Q);
    localparam int QN_W = $clog2(Q + 1);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_UTF8,
        PH_ENTITY
    } phase_t;

    case_mode_t       case_mode_reg;
    phase_t           phase_reg, phase_next;
    logic [CP_W-1:0]  part_reg, part_next;
    logic [1:0]       rem_reg, rem_next;
    logic [IDX_W-1:0] len_reg, len_next;
    logic             at_start_reg, at_start_next;
    logic [7:0]       buf_reg [Q];
    logic [7:0]       q_reg [Q];
    logic [7:0]       q_next [Q];
    logic [QN_W-1:0]  qn_reg, qn_next;
    logic             q_last_reg;
    logic [CP_W-1:0]  held_cp_reg;
    logic             held_last_reg;
    logic             m_valid_reg;
    out_t             m_data_reg;

    logic [7:0]       b;
    logic             last;
    logic             em, em_last, rp, buf_we;
    logic [CP_W-1:0]  em_cp, res_cp;
    logic [1:0]       rem_dec;
    ent_match_t       mt;

    assign b = cmd.from_queue ? q_reg[0] : s_data.data_byte;
    assign last = cmd.from_queue ? (qn_reg == QN_W'(1)) && q_last_reg : s_data.end_of_string;
    assign rem_dec = (rem_reg != 2'd0) ? rem_reg - 2'd1 : 2'd0;
    assign mt = ent_match({buf_reg[0], buf_reg[1], buf_reg[2], buf_reg[3]},
                          NAME_LEN_W'(len_reg));

    always_comb begin
        logic up;
        em = 1'b0;
        em_cp = '0;
        em_last = 1'b0;
        rp = 1'b0;
        buf_we = 1'b0;
        phase_next = phase_reg;
        part_next = part_reg;
        rem_next = rem_reg;
        len_next = len_reg;
        unique case (phase_reg)
            PH_ENTITY: begin
                if (b == CHAR_SEMI) begin
                    if (mt.hit) begin
                        em = 1'b1;
                        em_cp = mt.cp;
                        em_last = last;
                        phase_next = PH_IDLE;
                        len_next = '0;
                    end else begin
                        rp = 1'b1;
                    end
                end else if (len_reg >= IDX_W'(ENTITY_NAME_MAX) || last) begin
                    rp = 1'b1;
                end else begin
                    buf_we = 1'b1;
                    len_next = len_reg + IDX_W'(1);
                end
            end
            PH_UTF8: begin
                part_next = {part_reg[CP_W-7:0], b[5:0]};
                rem_next = rem_dec;
                if (rem_dec == 2'd0) begin
                    phase_next = PH_IDLE;
                    em = 1'b1;
                    em_cp = {part_reg[CP_W-7:0], b[5:0]};
                    em_last = last;
                end else if (last) begin
                    em = 1'b1;
                    em_cp = CP_SPACE;
                    em_last = 1'b1;
                end
            end
            PH_IDLE: begin
                if (b == CHAR_AMP) begin
                    if (last) begin
                        em = 1'b1;
                        em_cp = CP_AMP;
                        em_last = 1'b1;
                    end else begin
                        phase_next = PH_ENTITY;
                        len_next = '0;
                    end
                end else if (!b[7]) begin
                    em = 1'b1;
                    em_cp = CP_W'(b);
                    em_last = last;
                end else if (b[7:5] == 3'b110 || b[7:4] == 4'b1110 || b[7:3] == 5'b11110) begin
                    if (b[7:5] == 3'b110) begin
                        part_next = CP_W'(b[4:0]);
                        rem_next = 2'd1;
                    end else if (b[7:4] == 4'b1110) begin
                        part_next = CP_W'(b[3:0]);
                        rem_next = 2'd2;
                    end else begin
                        part_next = CP_W'(b[2:0]);
                        rem_next = 2'd3;
                    end
                    if (last) begin
                        em = 1'b1;
                        em_cp = CP_SPACE;
                        em_last = 1'b1;
                    end else begin
                        phase_next = PH_UTF8;
                    end
                end else begin
                    em = 1'b1;
                    em_cp = CP_SPACE;
                    em_last = last;
                end
            end
            default: begin
                phase_next = PH_IDLE;
            end
        endcase
        if (rp) begin
            em = 1'b1;
            em_cp = CP_AMP;
            em_last = 1'b0;
            phase_next = PH_IDLE;
            len_next = '0;
        end
        at_start_next = at_start_reg;
        if (em) begin
            at_start_next = 1'b0;
        end
        if (em && em_last) begin
            phase_next = PH_IDLE;
            part_next = '0;
            rem_next = 2'd0;
            len_next = '0;
            at_start_next = 1'b1;
        end
        up = (case_mode_reg == CASE_UPPER) || (case_mode_reg == CASE_CAP && at_start_reg);
        res_cp = em_cp;
        if (up && em_cp >= CP_W'(8'h61) && em_cp <= CP_W'(8'h7A)) begin
            res_cp = em_cp - CP_W'(32);
        end else if (case_mode_reg == CASE_LOWER && em_cp >= CP_W'(8'h41)
                     && em_cp <= CP_W'(8'h5A)) begin
            res_cp = em_cp + CP_W'(32);
        end
    end

    always_comb begin
        int src;
        src = 0;
        for (int i = 0; i < Q; i++) begin
            q_next[i] = q_reg[i];
        end
        qn_next = qn_reg;
        if (rp) begin
            for (int i = 0; i < Q; i++) begin
                src = i - int'(len_reg);
                if (i < int'(len_reg)) begin
                    q_next[i] = buf_reg[i];
                end else if (i == int'(len_reg)) begin
                    q_next[i] = b;
                end else if (src < Q) begin
                    q_next[i] = q_reg[IDX_W'(src)];
                end
            end
            qn_next = cmd.from_queue ? QN_W'(len_reg) + qn_reg
                                     : QN_W'(len_reg) + QN_W'(1);
        end else if (cmd.from_queue) begin
            for (int i = 0; i < Q - 1; i++) begin
                q_next[i] = q_reg[i + 1];
            end
            qn_next = qn_reg - QN_W'(1);
        end
    end

    assign status.emit = em;
    assign status.replay = rp;
    assign status.q_one = (qn_reg == QN_W'(1));
    assign status.out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            case_mode_reg <= CASE_NONE;
            phase_reg <= PH_IDLE;
            part_reg <= '0;
            rem_reg <= 2'd0;
            len_reg <= '0;
            at_start_reg <= 1'b1;
            qn_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case_mode_reg <= case_mode_t'(cfg_data);
            end
            if (cmd.step) begin
                phase_reg <= phase_next;
                part_reg <= part_next;
                rem_reg <= rem_next;
                len_reg <= len_next;
                at_start_reg <= at_start_next;
                qn_reg <= qn_next;
            end
            if (cmd.out_sel != OSEL_NONE) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.step) begin
            for (int i = 0; i < Q; i++) begin
                q_reg[i] <= q_next[i];
            end
            if (!cmd.from_queue) begin
                q_last_reg <= s_data.end_of_string;
            end
            if (buf_we) begin
                buf_reg[len_reg] <= b;
            end
        end
        if (cmd.held_load) begin
            held_cp_reg <= res_cp;
            held_last_reg <= em_last;
        end
        case (cmd.out_sel)
            OSEL_HELD: begin
                m_data_reg <= '{code_point: held_cp_reg, string_end: held_last_reg,
                                run_last: cmd.out_run_last};
            end
            OSEL_RES: begin
                m_data_reg <= '{code_point: res_cp, string_end: em_last,
                                run_last: cmd.out_run_last};
            end
            default: begin
            end
        endcase
    end

    assign m_valid = m_valid_reg;
    assign m_data = m_data_reg;

    a_end_resets: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.step && em && em_last |=> phase_reg == PH_IDLE && len_reg == '0 && at_start_reg)
        else $error("decoder not idle after string end");

    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        qn_reg <= QN_W'(Q))
        else $error("replay queue overflow");

endmodule

>>> src/utf8_entity_decoder.sv
// UTF-8 to code point decoder with HTML entity handling.
// Input channel s_valid/s_ready/s_data carries one byte per request with an
// end-of-string flag. Output channel m_valid/m_ready/m_data carries decoded
// code points with string_end and run_last (last result of the input byte).
// cfg_valid/cfg_ready/cfg_data writes the case mode; always ready.
// Throughput: one byte per cycle for plain text and UTF-8 while the output is
// free; the input is taken in the same cycle it is decoded, result registered.
// A byte that ends an unknown or unterminated entity starts a replay: the
// '&' is sent and the held name bytes plus that byte (up to ENTITY_NAME_MAX+1)
// are re-decoded one per cycle from a small replay queue while the output is
// free; the replay runs on when a replayed byte opens another bad entity, and
// a flush step follows when the final result sits in the hold register.
// During a replay each result is held back in the hold register so run_last is known.
// Reset: decoder idle, case mode none, at start of string, output empty.
// When m_ready is low the output register holds; input is refused and the
// replay sequencer stalls until the output can take a new result.
module utf8_entity_decoder #(
    parameter int ENTITY_NAME_MAX = uted_pkg::ENTITY_NAME_MAX_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  uted_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output uted_pkg::out_t m_data,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic [1:0]     cfg_data
);
    import uted_pkg::*;

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    uted_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    uted_dp #(
        .ENTITY_NAME_MAX (ENTITY_NAME_MAX)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

>>> tb/tb.sv
module tb;
    import uted_pkg::*;

    localparam int NAME_MAX = ENTITY_NAME_MAX_DEF;
    localparam int IDLE_PCT = 38;

    typedef enum logic [1:0] {
        DEC_IDLE,
        DEC_UTF8,
        DEC_ENTITY
    } dec_state_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    in_t        s_data = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    out_t       m_data;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [1:0] cfg_data = '0;

    utf8_entity_decoder i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    string known_names [6] = '{"nbsp", "lt", "gt", "amp", "quot", "apos"};
    int    known_cps [6] = '{160, 60, 62, 38, 34, 39};

    // decoder mirror
    case_mode_t      case_sel = CASE_NONE;
    dec_state_t      dec_state = DEC_IDLE;
    logic [CP_W-1:0] cp_acc = '0;
    int unsigned     cont_left = 0;
    logic [7:0]      name_buf [NAME_MAX+1];
    int unsigned     name_len = 0;
    bit              string_head = 1'b1;

    in_t  text_q [$];
    out_t step_cps [$];
    out_t want_cps [$];
    int   bytes_queued = 0;
    int   bytes_taken = 0;
    int   err_count = 0;
    bit   s_fire = 1'b0;
    bit   calm = 1'b0;

    initial begin
        forever #4 aclk = ~aclk;
    end

    initial begin
        #4000000;
        $display("CHECK FAILED");
        $finish;
    end

    task automatic report_mismatch(string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        err_count++;
    endtask

    function automatic logic [CP_W-1:0] fold_case(logic [CP_W-1:0] cp);
        bit up;
        up = (case_sel == CASE_UPPER) || (case_sel == CASE_CAP && string_head);
        if (up && cp >= "a" && cp <= "z") begin
            return cp - CP_W'(32);
        end
        if (case_sel == CASE_LOWER && cp >= "A" && cp <= "Z") begin
            return cp + CP_W'(32);
        end
        return cp;
    endfunction

    function automatic void put_cp(logic [CP_W-1:0] cp, bit last);
        out_t r;
        r.code_point = fold_case(cp);
        r.string_end = last;
        r.run_last = 1'b0;
        if (step_cps.size() < OUT_MAX) begin
            step_cps.push_back(r);
        end
        string_head = 1'b0;
        if (last) begin
            dec_state = DEC_IDLE;
            cp_acc = '0;
            cont_left = 0;
            name_len = 0;
            string_head = 1'b1;
        end
    endfunction

    function automatic void decode_byte(in_t item);
        logic [7:0]      pend_b [$];
        bit              pend_l [$];
        logic [7:0]      seq [NAME_MAX+2];
        logic [7:0]      b;
        bit              l;
        bit              hit;
        bit              same;
        logic [CP_W-1:0] hit_cp;
        int              n;
        int              j;
        int              k;
        out_t            r;
        step_cps.delete();
        pend_b.push_back(item.data_byte);
        pend_l.push_back(item.end_of_string);
        while (pend_b.size() != 0) begin
            b = pend_b[0];
            pend_b.delete(0);
            l = pend_l[0];
            pend_l.delete(0);
            if (dec_state == DEC_ENTITY) begin
                n = (name_len > NAME_MAX) ? NAME_MAX : name_len;
                for (j = 0; j < n; j++) begin
                    seq[j] = name_buf[j];
                end
                seq[n] = b;
                hit = 1'b0;
                hit_cp = '0;
                if (b == CHAR_SEMI) begin
                    name_len = n;
                    for (k = 0; k < 6; k++) begin
                        if (!hit && known_names[k].len() == n) begin
                            same = 1'b1;
                            for (j = 0; j < n; j++) begin
                                if (name_buf[j] != known_names[k][j]) begin
                                    same = 1'b0;
                                end
                            end
                            if (same) begin
                                hit = 1'b1;
                                hit_cp = CP_W'(known_cps[k]);
                            end
                        end
                    end
                end
                if (hit) begin
                    dec_state = DEC_IDLE;
                    name_len = 0;
                    put_cp(hit_cp, l);
                end else if (b == CHAR_SEMI || n >= NAME_MAX || l) begin
                    // bad name: '&', then the held bytes are decoded again
                    dec_state = DEC_IDLE;
                    name_len = 0;
                    put_cp(CP_AMP, 1'b0);
                    for (j = n; j >= 0; j--) begin
                        pend_b.insert(0, seq[j]);
                        pend_l.insert(0, l && j == n);
                    end
                end else begin
                    name_buf[n] = b;
                    name_len = n + 1;
                end
            end else if (dec_state == DEC_UTF8) begin
                cp_acc = {cp_acc[CP_W-7:0], b[5:0]};
                if (cont_left > 0) begin
                    cont_left--;
                end
                if (cont_left == 0) begin
                    dec_state = DEC_IDLE;
                    put_cp(cp_acc, l);
                end else if (l) begin
                    put_cp(CP_SPACE, 1'b1);
                end
            end else if (b == CHAR_AMP) begin
                if (l) begin
                    put_cp(CP_AMP, 1'b1);
                end else begin
                    dec_state = DEC_ENTITY;
                    name_len = 0;
                end
            end else if (!b[7]) begin
                put_cp(CP_W'(b), l);
            end else begin
                cont_left = 0;
                if (b[7:5] == 3'b110) begin
                    cp_acc = CP_W'(b[4:0]);
                    cont_left = 1;
                end else if (b[7:4] == 4'b1110) begin
                    cp_acc = CP_W'(b[3:0]);
                    cont_left = 2;
                end else if (b[7:3] == 5'b11110) begin
                    cp_acc = CP_W'(b[2:0]);
                    cont_left = 3;
                end
                if (cont_left == 0) begin
                    put_cp(CP_SPACE, l);
                end else if (l) begin
                    put_cp(CP_SPACE, 1'b1);
                end else begin
                    dec_state = DEC_UTF8;
                end
            end
        end
        for (j = 0; j < step_cps.size(); j++) begin
            r = step_cps[j];
            r.run_last = (j == step_cps.size() - 1);
            want_cps.push_back(r);
        end
    endfunction

    // request driver
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            m_ready <= 1'b0;
        end else begin
            if (!s_valid || s_fire) begin
                if (text_q.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    s_valid <= 1'b1;
                    s_data <= text_q[0];
                    text_q.delete(0);
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // monitor and checker
    always @(posedge aclk) begin : mon
        out_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (want_cps.size() == 0) begin
                    report_mismatch($sformatf("unexpected result cp=%h", m_data.code_point));
                end else begin
                    want = want_cps[0];
                    want_cps.delete(0);
                    if (m_data.code_point !== want.code_point) begin
                        report_mismatch($sformatf("code_point %h, want %h",
                                                  m_data.code_point, want.code_point));
                    end
                    if (m_data.string_end !== want.string_end) begin
                        report_mismatch($sformatf("string_end %b, want %b (cp %h)",
                                                  m_data.string_end, want.string_end,
                                                  want.code_point));
                    end
                    if (m_data.run_last !== want.run_last) begin
                        report_mismatch($sformatf("run_last %b, want %b (cp %h)",
                                                  m_data.run_last, want.run_last,
                                                  want.code_point));
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                case_sel = case_mode_t'(cfg_data);
            end
            if (s_valid && s_ready) begin
                decode_byte(s_data);
                bytes_taken++;
            end
        end
        s_fire <= aresetn && s_valid && s_ready;
    end

    task automatic push_item(logic [7:0] b, bit eos);
        in_t item;
        item.data_byte = b;
        item.end_of_string = eos;
        text_q.push_back(item);
        bytes_queued++;
    endtask

    task automatic write_case(case_mode_t mode);
        bit done;
        done = 1'b0;
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= mode;
        while (!done) begin
            @(posedge aclk);
            done = cfg_valid && cfg_ready;
        end
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (bytes_taken != bytes_queued || want_cps.size() != 0) begin
            @(negedge aclk);
        end
        repeat (20) @(negedge aclk);
    endtask

    function automatic logic [7:0] lead_byte(int len);
        case (len)
            2: begin
                return 8'hC0 | 8'($urandom_range(0, 31));
            end
            3: begin
                return 8'hE0 | 8'($urandom_range(0, 15));
            end
            default: begin
                return 8'hF0 | 8'($urandom_range(0, 7));
            end
        endcase
    endfunction

    function automatic logic [7:0] cont_byte();
        if ($urandom_range(0, 9) == 0) begin
            return 8'($urandom);
        end
        return 8'h80 | 8'($urandom_range(0, 63));
    endfunction

    task automatic add_rand_string();
        logic [7:0] s [$];
        int         kind;
        int         len;
        int         cut;
        int         j;
        int         k;
        string      nm;
        repeat ($urandom_range(1, 8)) begin
            kind = $urandom_range(0, 99);
            if (kind < 28) begin
                s.push_back($urandom_range(0, 1) ? 8'($urandom_range(65, 90))
                                                 : 8'($urandom_range(97, 122)));
            end else if (kind < 36) begin
                s.push_back(8'($urandom_range(0, 127)));
            end else if (kind < 52) begin
                len = $urandom_range(2, 4);
                s.push_back(lead_byte(len));
                repeat (len - 1) s.push_back(cont_byte());
            end else if (kind < 70) begin
                nm = known_names[$urandom_range(0, 5)];
                s.push_back(CHAR_AMP);
                for (j = 0; j < nm.len(); j++) begin
                    s.push_back(nm[j]);
                end
                s.push_back(CHAR_SEMI);
            end else if (kind < 80) begin
                // near-miss names: short, long, one letter off, or junk
                s.push_back(CHAR_AMP);
                cut = $urandom_range(0, 3);
                if (cut == 3) begin
                    repeat ($urandom_range(0, 8)) s.push_back(8'($urandom_range(97, 122)));
                end else begin
                    nm = known_names[$urandom_range(0, 5)];
                    k = $urandom_range(0, nm.len() - 1);
                    for (j = 0; j < nm.len() - (cut == 0 ? 1 : 0); j++) begin
                        s.push_back((cut == 2 && j == k) ? 8'($urandom_range(97, 122)) : nm[j]);
                    end
                    if (cut == 1) begin
                        s.push_back(8'($urandom_range(97, 122)));
                    end
                end
                if ($urandom_range(0, 9) < 6) begin
                    s.push_back(CHAR_SEMI);
                end
            end else if (kind < 87) begin
                s.push_back(CHAR_AMP);
                repeat ($urandom_range(1, 3)) s.push_back(8'($urandom));
            end else if (kind < 93) begin
                s.push_back($urandom_range(0, 1) ? 8'($urandom_range(8'h80, 8'hBF))
                                                 : 8'($urandom_range(8'hF8, 8'hFF)));
            end else begin
                s.push_back(8'($urandom));
            end
        end
        k = $urandom_range(0, 99);
        if (k < 12) begin
            len = $urandom_range(2, 4);
            s.push_back(lead_byte(len));
            repeat ($urandom_range(0, len - 2)) s.push_back(cont_byte());
        end else if (k < 17) begin
            s.push_back(CHAR_AMP);
        end
        for (j = 0; j < s.size(); j++) begin
            push_item(s[j], j == s.size() - 1);
        end
    endtask

    logic [8:0] directed_set [25] = '{
        {8'h00, 1'b0}, {8'h7F, 1'b0}, {8'hC3, 1'b0}, {CHAR_AMP, 1'b0},
        {8'hF7, 1'b0}, {8'hBF, 1'b0}, {8'hBF, 1'b0}, {8'hBF, 1'b0},
        {8'hFF, 1'b1},
        {8'h80, 1'b0}, {CHAR_AMP, 1'b0}, {"l", 1'b0}, {"t", 1'b0},
        {CHAR_SEMI, 1'b0}, {CHAR_AMP, 1'b0}, {"a", 1'b0}, {"b", 1'b0},
        {"c", 1'b0}, {"d", 1'b0}, {"e", 1'b0}, {"f", 1'b0}, {"g", 1'b1},
        {8'hE2, 1'b0}, {8'h82, 1'b1},
        {CHAR_AMP, 1'b1}
    };

    initial begin : stim
        int         mark;
        case_mode_t mode;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        write_case(CASE_NONE);
        foreach (directed_set[i]) begin
            push_item(directed_set[i][8:1], directed_set[i][0]);
        end
        drain();

        for (int p = 0; p < 5; p++) begin
            case (p)
                0: begin
                    mode = CASE_UPPER;
                end
                1: begin
                    mode = CASE_LOWER;
                end
                2: begin
                    mode = CASE_CAP;
                end
                3: begin
                    mode = CASE_NONE;
                end
                default: begin
                    mode = case_mode_t'($urandom_range(0, 3));
                end
            endcase
            write_case(mode);
            calm = (p == 2);
            mark = bytes_queued;
            while (bytes_queued - mark < 55) begin
                add_rand_string();
            end
            drain();
            calm = 1'b0;
        end

        if (err_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
